@@ rtl/lu_linear_solver_defines.svh @@
// Assertion macros for the solver top level, lu_linear_solver.
// Expects signals named clk and rst_n in the scope where they are used.
`ifndef LU_LINEAR_SOLVER_DEFINES_SVH
`define LU_LINEAR_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lu_pkg.sv @@
// Shared types, constants and arithmetic helpers for the LU solver.
// No dependencies; imported by every module of the block.
`default_nettype none
package lu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_BITS;
  // Accumulator holds the init word minus up to 63 rounded products.
  localparam int ACC_W     = PROD_W - FRAC_BITS + 7;
  // Quotient steps: |num| shifted by the fraction plus one carry bit.
  localparam int DIV_W     = WORD_BITS + FRAC_BITS + 1;
  localparam int DIV_CW    = $clog2(DIV_W);

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [DIV_W-1:0] QMAX = {{(DIV_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2**(FRAC_BITS-1));

  // Control of one cell of the solution chain.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Divider request and response.
  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
  } div_rsp_t;

  // Clamp an accumulator to the word range.
  function automatic word_t sat_word(input logic signed [ACC_W-1:0] a);
    if ((&a[ACC_W-1:WORD_BITS-1]) || !(|a[ACC_W-1:WORD_BITS-1])) begin
      return a[WORD_BITS-1:0];
    end else if (a[ACC_W-1]) begin
      return WMIN;
    end else begin
      return WMAX;
    end
  endfunction

  // Round an exact product to Q16.16: add one half, then floor.
  function automatic logic signed [ACC_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + RND_HALF;
    return ACC_W'(t >>> FRAC_BITS);
  endfunction

endpackage
`default_nettype wire

@@ rtl/lu_cell.sv @@
// One cell of the solution chain: holds one element and hands it to its
// neighbor on a shift. Depends on lu_pkg.
`default_nettype none
module lu_cell (
  input  wire                 clk,
  input  lu_pkg::cell_ctrl_t  ctrl,
  input  lu_pkg::word_t       load_data,
  input  lu_pkg::word_t       shift_in,
  output lu_pkg::word_t       q
);
  import lu_pkg::*;

  word_t val_r;

  // A load from the solver wins over a shift toward the output.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val_r <= load_data;
    end else if (ctrl.shift) begin
      val_r <= shift_in;
    end
  end

  assign q = val_r;

endmodule
`default_nettype wire

@@ rtl/lu_div.sv @@
// Iterative Q16.16 divider, one quotient bit per cycle, rounding to nearest
// with ties away from zero and saturating. Depends on lu_pkg.
`default_nettype none
module lu_div (
  input  wire               clk,
  input  wire               rst_n,
  input  lu_pkg::div_req_t  req,
  output lu_pkg::div_rsp_t  rsp
);
  import lu_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CW-1:0]     cnt_r;
  logic [WORD_BITS-1:0]  rem_r;
  logic [DIV_W-1:0]      dvd_r;
  logic [DIV_W-1:0]      quo_r;
  logic [WORD_BITS-1:0]  md_r;
  logic                  neg_r;
  word_t                 res_r;

  logic [WORD_BITS-1:0]  abs_num;
  logic [WORD_BITS-1:0]  abs_den;
  logic [DIV_W-1:0]      dividend;
  logic [WORD_BITS:0]    r2;
  logic                  ge;
  logic [WORD_BITS:0]    diff;
  logic [DIV_W-1:0]      q_new;
  word_t                 q_fin;

  // Magnitudes; the rounding half of the divisor is folded into the dividend.
  always_comb begin
    abs_num  = req.num[WORD_BITS-1] ? (~req.num + 1'b1) : req.num;
    abs_den  = req.den[WORD_BITS-1] ? (~req.den + 1'b1) : req.den;
    dividend = {1'b0, abs_num, {FRAC_BITS{1'b0}}} + DIV_W'(abs_den >> 1);
  end

  // One restoring step.
  always_comb begin
    r2    = {rem_r, dvd_r[DIV_W-1]};
    ge    = r2 >= {1'b0, md_r};
    diff  = r2 - {1'b0, md_r};
    q_new = {quo_r[DIV_W-2:0], ge};
    if (q_new > QMAX) begin
      q_fin = neg_r ? WMIN : WMAX;
    end else begin
      q_fin = neg_r ? -word_t'(q_new[WORD_BITS-1:0]) : word_t'(q_new[WORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          done_r <= 1'b1;
          res_r  <= '0;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= '0;
          dvd_r  <= dividend;
          quo_r  <= '0;
          md_r   <= abs_den;
          neg_r  <= req.num[WORD_BITS-1] ^ req.den[WORD_BITS-1];
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
        quo_r <= q_new;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= q_fin;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = res_r;

endmodule
`default_nettype wire

@@ rtl/lu_linear_solver.sv @@
// Matrix elements are written while idle; the last starts factoring, where each
// element costs its k products plus, below the diagonal, a quotient, all via one
// shared multiplier and one bit-serial divider. A full right-hand vector starts a
// solve (a quotient per element in back substitution); n results then leave one
// per cycle from the solution chain when not stalled; inputs stall meanwhile.
// Reset is synchronous, active low: order 8, no matrix factored, flags clear.
`default_nettype none
`include "lu_linear_solver_defines.svh"
module lu_linear_solver #(
  parameter int MAX_ORDER = 8
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  wire            in_command,
  input  lu_pkg::word_t  in_value,
  output logic           out_valid,
  input  wire            out_stall,
  output lu_pkg::word_t  out_solution,
  output logic [2:0]     out_element_index,
  output logic           out_last,
  output logic           out_singular,
  input  wire            cfg_wr_en,
  input  wire [3:0]      cfg_wr_data
);
  import lu_pkg::*;

  localparam int IW = $clog2(MAX_ORDER);
  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_INIT2 = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_DIVS  = 4'd7;
  localparam logic [3:0] S_DIVW  = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam logic [1:0] PH_FACT = 2'd0;
  localparam logic [1:0] PH_FWD  = 2'd1;
  localparam logic [1:0] PH_BACK = 2'd2;

  logic [3:0]              state_r;
  logic [1:0]              phase_r;
  logic [NW-1:0]           n_r;
  logic [IW-1:0]           lrow_r, lcol_r, rc_r, i_r, j_r, ecnt_r;
  logic [NW-1:0]           k_r;
  logic                    factored_r, zpf_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  word_t                   res_r;
  word_t                   rhs_r [MAX_ORDER];
  word_t                   fs_mem [MAX_ORDER*MAX_ORDER];
  word_t                   mem_qa, mem_qb;

  logic [NW-1:0]  nm1, kstart, kend;
  logic           need_div, in_xfer, out_xfer;
  logic [IW-1:0]  ld_row, ld_col, x_idx;
  logic [AW-1:0]  ra, rb, wa;
  logic           we;
  word_t          wd, opb, x_sel_q;
  word_t          x_q [MAX_ORDER];
  div_req_t       div_req;
  div_rsp_t       div_rsp;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r * MAX_ORDER) + AW'(c);
  endfunction

  assign nm1      = n_r - NW'(1);
  assign in_stall = state_r != S_IDLE;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign ld_row   = factored_r ? '0 : lrow_r;
  assign ld_col   = factored_r ? '0 : lcol_r;

  // Range of the product index and whether the element needs a quotient.
  always_comb begin
    case (phase_r)
      PH_FACT: begin
        kstart = '0;
        kend   = (j_r <= i_r) ? NW'(j_r) : NW'(i_r);
      end
      PH_FWD: begin
        kstart = '0;
        kend   = NW'(i_r);
      end
      PH_BACK: begin
        kstart = NW'(i_r) + NW'(1);
        kend   = n_r;
      end
      default: begin
        kstart = '0;
        kend   = '0;
      end
    endcase
    need_div = ((phase_r == PH_FACT) && (j_r > i_r)) || (phase_r == PH_BACK);
  end

  // Factor store addressing: two read ports, one write port.
  always_comb begin
    case (state_r)
      S_INIT:  ra = cell_addr(j_r, i_r);
      S_RD:    ra = cell_addr((phase_r == PH_FACT) ? j_r : i_r, k_r[IW-1:0]);
      default: ra = cell_addr(i_r, i_r);
    endcase
    rb = cell_addr(k_r[IW-1:0], i_r);
    we = 1'b0;
    wa = cell_addr(j_r, i_r);
    wd = res_r;
    if (in_xfer && !in_command) begin
      we = 1'b1;
      wa = cell_addr(ld_row, ld_col);
      wd = in_value;
    end else if ((state_r == S_WR) && (phase_r == PH_FACT)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fs_mem[wa] <= wd;
    end
    mem_qa <= fs_mem[ra];
    mem_qb <= fs_mem[rb];
  end

  // Solution chain: the solver loads cells by index, a result transfer
  // shifts every element one cell toward the output.
  assign x_idx   = (state_r == S_MUL) ? k_r[IW-1:0] : i_r;
  assign x_sel_q = x_q[x_idx];

  for (genvar m = 0; m < MAX_ORDER; m++) begin : g_chain
    cell_ctrl_t ctrl;
    word_t      sin;
    assign ctrl.load  = (state_r == S_WR) && (phase_r != PH_FACT) && (i_r == IW'(m));
    assign ctrl.shift = out_xfer;
    if (m == MAX_ORDER - 1) begin : g_end
      assign sin = '0;
    end else begin : g_mid
      assign sin = x_q[m+1];
    end
    lu_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (res_r),
      .shift_in  (sin),
      .q         (x_q[m])
    );
  end

  // Shared divider.
  assign div_req.start = state_r == S_DIVS;
  assign div_req.num   = res_r;
  assign div_req.den   = mem_qa;

  lu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign opb = (phase_r == PH_FACT) ? mem_qb : x_sel_q;

  // Payload datapath: multiply, accumulate, saturate, capture quotients and rhs words.
  always_ff @(posedge clk) begin
    case (state_r)
      S_INIT2: begin
        if (phase_r == PH_FACT) begin
          acc_r <= ACC_W'(mem_qa);
        end else if (phase_r == PH_FWD) begin
          acc_r <= ACC_W'(rhs_r[i_r]);
        end else begin
          acc_r <= ACC_W'(x_sel_q);
        end
      end
      S_MUL:   prod_r <= mem_qa * opb;
      S_ACC:   acc_r  <= acc_r - rnd_prod(prod_r);
      S_FIN:   res_r  <= sat_word(acc_r);
      S_DIVW: begin
        if (div_rsp.done) begin
          res_r <= div_rsp.quo;
        end
      end
      default: begin
      end
    endcase
    if (in_xfer && in_command && factored_r) begin
      rhs_r[rc_r] <= in_value;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= PH_FACT;
      n_r        <= NW'((MAX_ORDER < 8) ? MAX_ORDER : 8);
      lrow_r     <= '0;
      lcol_r     <= '0;
      rc_r       <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      ecnt_r     <= '0;
      factored_r <= 1'b0;
      zpf_r      <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer && !in_command) begin
            if (factored_r) begin
              factored_r <= 1'b0;
              zpf_r      <= 1'b0;
              rc_r       <= '0;
            end
            if ((NW'(ld_row) == nm1) && (NW'(ld_col) == nm1)) begin
              lrow_r  <= '0;
              lcol_r  <= '0;
              zpf_r   <= 1'b0;
              phase_r <= PH_FACT;
              i_r     <= '0;
              j_r     <= '0;
              state_r <= S_INIT;
            end else if (NW'(ld_col) == nm1) begin
              lcol_r <= '0;
              lrow_r <= ld_row + 1'b1;
            end else begin
              lcol_r <= ld_col + 1'b1;
              lrow_r <= ld_row;
            end
          end else if (in_xfer && in_command && factored_r) begin
            if (NW'(rc_r) == nm1) begin
              rc_r    <= '0;
              phase_r <= PH_FWD;
              i_r     <= '0;
              state_r <= S_INIT;
            end else begin
              rc_r <= rc_r + 1'b1;
            end
          end
        end
        S_INIT: state_r <= S_INIT2;
        S_INIT2: begin
          k_r     <= kstart;
          state_r <= (kstart < kend) ? S_RD : S_FIN;
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          k_r     <= k_r + 1'b1;
          state_r <= ((k_r + NW'(1)) < kend) ? S_RD : S_FIN;
        end
        S_FIN: state_r <= need_div ? S_DIVS : S_WR;
        S_DIVS: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_rsp.done) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          state_r <= S_INIT;
          case (phase_r)
            PH_FACT: begin
              if ((j_r == i_r) && (res_r == '0)) begin
                zpf_r <= 1'b1;
              end
              if (NW'(j_r) == nm1) begin
                j_r <= '0;
                if (NW'(i_r) == nm1) begin
                  factored_r <= 1'b1;
                  state_r    <= S_IDLE;
                end else begin
                  i_r <= i_r + 1'b1;
                end
              end else begin
                j_r <= j_r + 1'b1;
              end
            end
            PH_FWD: begin
              if (NW'(i_r) == nm1) begin
                phase_r <= PH_BACK;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end
            default: begin
              if (i_r == '0) begin
                ecnt_r  <= '0;
                state_r <= S_EMIT;
              end else begin
                i_r <= i_r - 1'b1;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (out_xfer) begin
            ecnt_r <= ecnt_r + 1'b1;
            if (NW'(ecnt_r) == nm1) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // The user makes order writes only while idle, not enforced; they restart loading.
      if (cfg_wr_en) begin
        if (cfg_wr_data == 4'd0) begin
          n_r <= NW'(1);
        end else if (int'(cfg_wr_data) > MAX_ORDER) begin
          n_r <= NW'(MAX_ORDER);
        end else begin
          n_r <= NW'(cfg_wr_data);
        end
        lrow_r     <= '0;
        lcol_r     <= '0;
        rc_r       <= '0;
        factored_r <= 1'b0;
        zpf_r      <= 1'b0;
      end
    end
  end

  // Result channel, straight from the head of the chain.
  assign out_valid         = state_r == S_EMIT;
  assign out_solution      = x_q[0];
  assign out_element_index = 3'(ecnt_r);
  assign out_last          = NW'(ecnt_r) == nm1;
  assign out_singular      = zpf_r;

  `LU_ASSERT_IMPL(a_emit_blocks_input, out_valid, in_stall, "input taken during emission")
  `LU_ASSERT_NEXT(a_last_ends_burst, out_xfer && out_last, !out_valid, "burst ran past last")
  `LU_ASSERT_IMPL(a_div_done_waited, div_rsp.done, state_r == S_DIVW, "stray divider result")
  `LU_ASSERT_IMPL(a_emit_after_factor, out_valid, factored_r, "results without factors")

endmodule
`default_nettype wire

@@ verif/tb_lu_linear_solver.sv @@
// Self-checking testbench for lu_linear_solver: loads matrices and right-hand vectors,
// predicts each solution with a fixed-point LU solver of its own and checks every transfer.
// Depends on lu_pkg and the lu_linear_solver RTL.
`default_nettype none
module tb_lu_linear_solver;
  import lu_pkg::*;

  localparam int ORDER_MAX = 8;
  localparam int CMD_MATRIX = 0;
  localparam int CMD_RHS = 1;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [31:0] solution;
    logic [2:0]  index;
    logic        last;
    logic        singular;
  } solution_t;

  typedef struct {
    bit          command;
    logic [31:0] value;
    bit          checked;
    logic [31:0] solution;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic        in_command = 1'b0;
  word_t       in_value = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  word_t       out_solution;
  wire  [2:0]  out_element_index;
  wire         out_last;
  wire         out_singular;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;

  lu_linear_solver u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_solution(out_solution),
    .out_element_index(out_element_index), .out_last(out_last),
    .out_singular(out_singular),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Solver state mirrored by the testbench.
  longint lu_cells [ORDER_MAX][ORDER_MAX];
  longint rhs_vec [ORDER_MAX];
  int     load_count;
  bit     is_factored;
  bit     zero_pivot;
  int     order;
  solution_t expected_q[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  longint cycles = 0;

  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;

  function automatic longint clamp(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Rounded Q16.16 product: add one half, then floor (arithmetic shift).
  function automatic longint fx_mul(input longint a, input longint b);
    longint t;
    t = a * b + 64'sd32768;
    return t >>> 16;
  endfunction

  // Rounded Q16.16 quotient, ties away from zero; zero divisor flagged.
  function automatic longint fx_div(input longint num, input longint den, inout bit zero);
    bit neg;
    longint unsigned mn, md, q;
    if (den == 0) begin
      zero = 1'b1;
      return 0;
    end
    neg = (num < 0) != (den < 0);
    mn = longint'(num < 0 ? -num : num) << 16;
    md = den < 0 ? -den : den;
    q = (mn + md / 2) / md;
    if (q > longint'(WORD_HI)) return neg ? WORD_LO : WORD_HI;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // In-place Doolittle factoring of the loaded matrix.
  function automatic void factor_matrix();
    bit zero;
    longint acc;
    zero = 1'b0;
    for (int i = 0; i < order; i++) begin
      for (int j = 0; j < order; j++) begin
        acc = lu_cells[j][i];
        if (j <= i) begin
          for (int k = 0; k < j; k++) acc -= fx_mul(lu_cells[j][k], lu_cells[k][i]);
          lu_cells[j][i] = clamp(acc);
        end else begin
          for (int k = 0; k < i; k++) acc -= fx_mul(lu_cells[j][k], lu_cells[k][i]);
          lu_cells[j][i] = fx_div(clamp(acc), lu_cells[i][i], zero);
        end
      end
      if (lu_cells[i][i] == 0) zero = 1'b1;
    end
    zero_pivot = zero;
  endfunction

  // Forward and back substitution; queues the n expected solution elements.
  function automatic void solve_system();
    longint x [ORDER_MAX];
    longint acc;
    bit dummy;
    solution_t s;
    dummy = 1'b0;
    for (int i = 0; i < order; i++) begin
      acc = rhs_vec[i];
      for (int j = 0; j < i; j++) acc -= fx_mul(lu_cells[i][j], x[j]);
      x[i] = clamp(acc);
    end
    for (int i = order - 1; i >= 0; i--) begin
      acc = x[i];
      for (int j = i + 1; j < order; j++) acc -= fx_mul(lu_cells[i][j], x[j]);
      x[i] = fx_div(clamp(acc), lu_cells[i][i], dummy);
    end
    for (int i = 0; i < order; i++) begin
      s.solution = x[i][31:0];
      s.index = i[2:0];
      s.last = (i == order - 1);
      s.singular = zero_pivot;
      expected_q.push_back(s);
    end
  endfunction

  function automatic void predict_transfer(input bit command, input logic [31:0] value);
    longint v;
    v = longint'($signed(value));
    if (command == CMD_MATRIX) begin
      if (is_factored) begin
        is_factored = 1'b0;
        zero_pivot = 1'b0;
        load_count = 0;
      end
      lu_cells[load_count / order][load_count % order] = v;
      load_count++;
      if (load_count >= order * order) begin
        factor_matrix();
        is_factored = 1'b1;
        load_count = 0;
      end
    end else if (is_factored) begin
      rhs_vec[load_count % ORDER_MAX] = v;
      load_count++;
      if (load_count >= order) begin
        load_count = 0;
        solve_system();
      end
    end
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    solution_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, solution %h", $time, out_solution);
      end else begin
        e = expected_q.pop_front();
        if (out_solution !== e.solution) begin
          errors++;
          $display("%0t: solution expected %h actual %h", $time, e.solution, out_solution);
        end
        if (out_element_index !== e.index) begin
          errors++;
          $display("%0t: index expected %0d actual %0d", $time, e.index, out_element_index);
        end
        if (out_last !== e.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, e.last, out_last);
        end
        if (out_singular !== e.singular) begin
          errors++;
          $display("%0t: singular expected %b actual %b", $time, e.singular, out_singular);
        end
      end
    end
  end

  // Receiver stalls, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // One transfer: drive at the falling edge, hold until accepted. Valid stays
  // high afterwards until the next item, an idle cycle or a drain replaces it.
  task automatic send_item(input bit command, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= command;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transfer(command, value);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_order(input logic [3:0] n);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    order = (n < 1) ? 1 : (n > ORDER_MAX ? ORDER_MAX : int'(n));
    load_count = 0;
    is_factored = 1'b0;
    zero_pivot = 1'b0;
  endtask

  function automatic logic [31:0] random_value(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
      default: return 32'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // Random system: mostly full matrix plus vectors, sometimes noise.
  task automatic random_system(input int vectors);
    int kind;
    kind = $urandom_range(9) == 0 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
    if ($urandom_range(7) == 0) send_item(CMD_RHS, $urandom());
    for (int i = 0; i < order * order; i++) begin
      if (i / order == i % order && kind != 0)
        send_item(CMD_MATRIX, 32'($signed($urandom_range(6 * 65536)) + 65536)
                  ^ ($urandom_range(1) ? 32'hFFFFFFFF : 32'h0));
      else
        send_item(CMD_MATRIX, random_value(kind));
    end
    for (int v = 0; v < vectors; v++)
      for (int i = 0; i < order; i++) send_item(CMD_RHS, random_value(kind));
  endtask

  stim_row_t directed [$];
  int sent;

  function automatic void add_row(input bit command, input logic [31:0] value,
                                  input bit checked = 1'b0, input logic [31:0] sol = '0);
    stim_row_t r;
    r.command = command;
    r.value = value;
    r.checked = checked;
    r.solution = sol;
    directed.push_back(r);
  endfunction

  initial begin
    solution_t e;
    order = ORDER_MAX;
    load_count = 0;
    is_factored = 1'b0;
    zero_pivot = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at order 1, then order 2 with a zero pivot.
    write_order(4'd0);
    add_row(CMD_RHS, 32'h0001_0000);                  // ignored before factoring
    add_row(CMD_MATRIX, 32'h0001_0000);               // a = 1.0
    add_row(CMD_RHS, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
    add_row(CMD_RHS, 32'h8000_0000, 1'b1, 32'h8000_0000);
    add_row(CMD_RHS, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_row(CMD_MATRIX, 32'h0000_0000);               // zero pivot
    add_row(CMD_RHS, 32'h0003_0000, 1'b1, 32'h0000_0000);
    add_row(CMD_MATRIX, 32'h0000_0001);               // tiny pivot saturates
    add_row(CMD_RHS, 32'h0001_0000, 1'b1, 32'h7FFF_FFFF);
    add_row(CMD_MATRIX, 32'h8000_0000);
    add_row(CMD_RHS, 32'h8000_0000, 1'b1, 32'h0001_0000);
    foreach (directed[i]) begin
      send_item(directed[i].command, directed[i].value);
      if (directed[i].checked && expected_q.size() != 0) begin
        e = expected_q[expected_q.size() - 1];
        if (e.solution !== directed[i].solution) begin
          errors++;
          $display("%0t: table row %0d expected %h predicted %h", $time, i,
                   directed[i].solution, e.solution);
        end
      end
    end
    write_order(4'd2);
    send_item(CMD_MATRIX, 32'h0000_0000);
    send_item(CMD_MATRIX, 32'h0001_0000);
    send_item(CMD_MATRIX, 32'h0001_0000);
    send_item(CMD_MATRIX, 32'h0001_0000);
    send_item(CMD_RHS, 32'hFFFF_FFFF);
    send_item(CMD_RHS, 32'h7FFF_FFFF);

    // Random phases with varied idling and sizes.
    sent = 0;
    for (int phase = 0; sent < 190; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      case (phase % 6)
        0: write_order(4'd8);
        1: write_order(4'd15);
        2: write_order(4'd1);
        default: write_order(4'($urandom_range(2, 4)));
      endcase
      random_system(2);
      sent += order * order + 2 * order;
      if (phase == 3) drain();
    end

    send_idle_pct = 0;
    drain();
    recv_stall_pct = 0;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/lu_pkg.sv
rtl/lu_cell.sv
rtl/lu_div.sv
rtl/lu_linear_solver.sv
verif/tb_lu_linear_solver.sv
